FILE: rtl/pwm_capture_duty_frequency_macros.svh
// Assertion macros for the PWM capture measurer.
// Used by the top level; no other dependencies.
`ifndef PWM_CAPTURE_DUTY_FREQUENCY_MACROS_SVH
`define PWM_CAPTURE_DUTY_FREQUENCY_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked at the same edge.
`define PCDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcdf assertion failed");
// Implication checked at the following edge.
`define PCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcdf assertion failed");
`else
`define PCDF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define PCDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/pcdf_pkg.sv
// Shared types and constants of the PWM capture measurer.
// No dependencies; used by every RTL module of the block.
package pcdf_pkg;

    localparam int TIME_W = 16;  // capture time and tick count fields
    localparam int TICK_W = 24;  // tick rate, frequency, divider dividend
    localparam int DUTY_W = 7;

    localparam logic [TICK_W-1:0] TICK_HZ_RESET = 24'd1000000;
    localparam logic [DUTY_W-1:0] PERCENT       = 7'd100;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_EDGE  = 1'b1;

    typedef struct packed {
        logic              action;
        logic              edge_rising;
        logic [TIME_W-1:0] capture_time;
    } cmd_t;

    typedef struct packed {
        logic [TICK_W-1:0] frequency;
        logic [DUTY_W-1:0] duty_percent;
        logic [TIME_W-1:0] high_ticks;
        logic [TIME_W-1:0] low_ticks;
        logic              period_error;
    } rsp_t;

    // Measurement phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RISE1 = 2'd1,
        PH_FALL  = 2'd2,
        PH_RISE2 = 2'd3
    } phase_t;

    // Sequencer state
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FREQ,
        ST_DUTY,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [TICK_W-1:0] quotient;
    } div_rsp_t;

endpackage

FILE: rtl/pcdf_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on pcdf_pkg.
module pcdf_div #(
    parameter int DVW = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pcdf_pkg::div_req_t  req,
    input  logic [DVW-1:0]      divisor,
    output pcdf_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(pcdf_pkg::TICK_W + 1);

    logic [pcdf_pkg::TICK_W-1:0] quo_reg, quo_next;
    logic [DVW-1:0]              rem_reg, rem_next;
    logic [DVW-1:0]              dvs_reg, dvs_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        done_reg, done_next;

    logic [DVW:0] trial;
    logic [DVW:0] diff;
    logic         fits;

    assign trial = {rem_reg, quo_reg[pcdf_pkg::TICK_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CNT_W'(pcdf_pkg::TICK_W);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[DVW-1:0] : trial[DVW-1:0];
            quo_next = {quo_reg[pcdf_pkg::TICK_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/pcdf_seq.sv
// Edge tracking and result sequencer; drives the shared divider.
// Depends on pcdf_pkg.
module pcdf_seq #(
    parameter int TW = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    input  pcdf_pkg::cmd_t                cmd,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output pcdf_pkg::rsp_t                rsp,
    input  logic [pcdf_pkg::TICK_W-1:0]   tick_hz,
    output pcdf_pkg::div_req_t            div_req,
    output logic [TW:0]                   div_divisor,
    input  pcdf_pkg::div_rsp_t            div_rsp
);

    localparam int PROD_W = TW + pcdf_pkg::DUTY_W;

    pcdf_pkg::seq_state_t state_reg, state_next;
    pcdf_pkg::phase_t     phase_reg, phase_next;

    logic [TW-1:0]     rise_reg, rise_next;
    logic [TW-1:0]     fall_reg, fall_next;
    logic [TW-1:0]     high_reg, high_next;
    logic [TW-1:0]     low_reg, low_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [pcdf_pkg::TICK_W-1:0] freq_reg, freq_next;
    logic [pcdf_pkg::DUTY_W-1:0] duty_reg, duty_next;
    logic              err_reg, err_next;
    logic              rsp_valid_reg, rsp_valid_next;
    pcdf_pkg::rsp_t    rsp_reg, rsp_next;

    logic [TW-1:0]     t;
    logic [TW:0]       period;
    logic [PROD_W-1:0] prod_full;
    logic              accept;

    assign t         = cmd.capture_time[TW-1:0];
    assign period    = {1'b0, high_reg} + {1'b0, low_reg};
    assign prod_full = {{pcdf_pkg::DUTY_W{1'b0}}, high_reg}
                     * {{TW{1'b0}}, pcdf_pkg::PERCENT};
    assign cmd_stall = (state_reg != pcdf_pkg::ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;

    assign div_divisor = period;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        rise_next      = rise_reg;
        fall_next      = fall_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        prod_next      = prod_reg;
        freq_next      = freq_reg;
        duty_next      = duty_reg;
        err_next       = err_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        div_req.start    = 1'b0;
        div_req.dividend = tick_hz;

        unique case (state_reg)
            pcdf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.action == pcdf_pkg::ACT_START)
                    begin
                        phase_next = pcdf_pkg::PH_RISE1;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            pcdf_pkg::PH_RISE1:
                            begin
                                if (cmd.edge_rising)
                                begin
                                    rise_next  = t;
                                    phase_next = pcdf_pkg::PH_FALL;
                                end
                            end
                            pcdf_pkg::PH_FALL:
                            begin
                                if (!cmd.edge_rising)
                                begin
                                    fall_next  = t;
                                    phase_next = pcdf_pkg::PH_RISE2;
                                end
                            end
                            pcdf_pkg::PH_RISE2:
                            begin
                                if (cmd.edge_rising)
                                begin
                                    high_next  = fall_reg - rise_reg;
                                    low_next   = t - fall_reg;
                                    phase_next = pcdf_pkg::PH_IDLE;
                                    state_next = pcdf_pkg::ST_MUL;
                                end
                            end
                            pcdf_pkg::PH_IDLE:
                            begin
                                // edges ignored until started
                            end
                        endcase
                    end
                end
            end
            pcdf_pkg::ST_MUL:
            begin
                prod_next = prod_full;
                if (period == '0)
                begin
                    freq_next  = '0;
                    duty_next  = '0;
                    err_next   = 1'b1;
                    state_next = pcdf_pkg::ST_DONE;
                end
                else
                begin
                    err_next      = 1'b0;
                    div_req.start = 1'b1;
                    state_next    = pcdf_pkg::ST_FREQ;
                end
            end
            pcdf_pkg::ST_FREQ:
            begin
                div_req.dividend = pcdf_pkg::TICK_W'(prod_reg);
                if (div_rsp.done)
                begin
                    freq_next     = div_rsp.quotient;
                    div_req.start = 1'b1;
                    state_next    = pcdf_pkg::ST_DUTY;
                end
            end
            pcdf_pkg::ST_DUTY:
            begin
                if (div_rsp.done)
                begin
                    duty_next  = div_rsp.quotient[pcdf_pkg::DUTY_W-1:0];
                    state_next = pcdf_pkg::ST_DONE;
                end
            end
            pcdf_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.frequency    = freq_reg;
                    rsp_next.duty_percent = duty_reg;
                    rsp_next.high_ticks   = pcdf_pkg::TIME_W'(high_reg);
                    rsp_next.low_ticks    = pcdf_pkg::TIME_W'(low_reg);
                    rsp_next.period_error = err_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = pcdf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcdf_pkg::ST_IDLE;
            phase_reg     <= pcdf_pkg::PH_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rise_reg <= rise_next;
        fall_reg <= fall_next;
        high_reg <= high_next;
        low_reg  <= low_next;
        prod_reg <= prod_next;
        freq_reg <= freq_next;
        duty_reg <= duty_next;
        err_reg  <= err_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/pwm_capture_duty_frequency.sv
// PWM duty and frequency measurer from input-capture time stamps.
// Command request channel: cmd_valid / cmd_stall / cmd (pcdf_pkg::cmd_t).
//   action start arms the block; action edge delivers a captured edge.
//   The block waits for rise, fall, rise; wrong-polarity edges are dropped.
// Result request channel: rsp_valid / rsp_stall / rsp (pcdf_pkg::rsp_t).
//   One result per completed rise-fall-rise sequence.
// Config: tick_hz_we / tick_hz_wdata write the tick rate (reset 1000000).
// Sequence: a start or a non-completing edge leaves the block idle and ready
//   for the next command. The completing edge stalls the command side until
//   the result is loaded: the block registers high*100 and launches the
//   tick_hz/period division, then the high*100/period division, each giving
//   24 quotient bits on the single 1-bit-per-cycle divider, then loads the
//   result. A zero period skips both divisions.
// The result sits in an output register; further commands are taken while
//   it waits. A stalled receiver holds back the next result load, and the
//   command side stays stalled until that load goes through.
// Reset clears the phase to idle, drops any pending result and restores
//   tick_hz; a start request is needed before the first measurement.
// COUNT_WIDTH sets the capture counter width; times wrap at
//   2^min(COUNT_WIDTH,16). Depends on pcdf_pkg, pcdf_div, pcdf_seq, macros.
`include "pwm_capture_duty_frequency_macros.svh"

module pwm_capture_duty_frequency #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    output logic                        cmd_stall,
    input  pcdf_pkg::cmd_t              cmd,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output pcdf_pkg::rsp_t              rsp,
    input  logic                        tick_hz_we,
    input  logic [pcdf_pkg::TICK_W-1:0] tick_hz_wdata
);

    // effective timestamp width: capture field is only 16 bits wide
    localparam int TW = (COUNT_WIDTH < pcdf_pkg::TIME_W) ? COUNT_WIDTH
                                                          : pcdf_pkg::TIME_W;

    logic [pcdf_pkg::TICK_W-1:0] tick_hz_reg;
    pcdf_pkg::div_req_t          div_req;
    pcdf_pkg::div_rsp_t          div_rsp;
    logic [TW:0]                 div_divisor;

    // tick rate register, dividend of the frequency division
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_hz_reg <= pcdf_pkg::TICK_HZ_RESET;
        end
        else if (tick_hz_we)
        begin
            tick_hz_reg <= tick_hz_wdata;
        end
    end

    pcdf_seq #(
        .TW (TW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .tick_hz     (tick_hz_reg),
        .div_req     (div_req),
        .div_divisor (div_divisor),
        .div_rsp     (div_rsp)
    );

    // shared divider for frequency and duty
    pcdf_div #(
        .DVW (TW + 1)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .divisor (div_divisor),
        .rsp     (div_rsp)
    );

    // divider only runs while the command side is held off
    `PCDF_ASSERT_NOW(a_div_start_busy, clk, rst_n, div_req.start, cmd_stall)
    `PCDF_ASSERT_NOW(a_div_done_busy, clk, rst_n, div_rsp.done, cmd_stall)
    // a division never completes in the cycle after launch
    `PCDF_ASSERT_NEXT(a_div_multi, clk, rst_n, div_req.start, !div_rsp.done)
    // zero period reports zeros everywhere; otherwise duty stays in range
    `PCDF_ASSERT_NOW(a_err_zero, clk, rst_n, rsp_valid && rsp.period_error, (rsp.frequency == '0) && (rsp.duty_percent == '0) && (rsp.high_ticks == '0) && (rsp.low_ticks == '0))
    `PCDF_ASSERT_NOW(a_duty_range, clk, rst_n, rsp_valid && !rsp.period_error, rsp.duty_percent <= pcdf_pkg::PERCENT)

endmodule
